// ----- design/mmse_pkg.sv -----
package mmse_pkg;

    // Q8.16 word layout
    localparam int Q_W    = 24;
    localparam int FRAC_W = 16;
    localparam int INT_W  = Q_W - FRAC_W;
    localparam logic [Q_W-1:0] Q_MAX = {Q_W{1'b1}};

    // configuration and result widths
    localparam int CFG_W  = 3;
    localparam int USED_W = 3;
    localparam logic [CFG_W-1:0]  MIN_CORNERS_RST = 3'd3;
    localparam logic [USED_W-1:0] USED_MAX        = 3'd7;

    // default geometry
    localparam int WINDOW_RADIUS_DEF = 2;
    localparam int MAX_CORNERS_DEF   = 4;

    // divider: one quotient bit a cycle
    localparam int DIV_STEPS = Q_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic           start;
        logic [Q_W-1:0] dividend;
        logic [Q_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
    } div_stat_t;

endpackage

// ----- design/mmse_sort_cell.sv -----
// One slot of a sorted insertion chain. Ascending from cell 0; empty cells
// sit at the high end.
module mmse_sort_cell #(
    parameter int WIDTH = mmse_pkg::Q_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ins,
    input  logic             clr,
    input  logic [WIDTH-1:0] new_val,
    input  logic             left_gt,
    input  logic [WIDTH-1:0] left_val,
    input  logic             left_full,
    output logic             gt,
    output logic [WIDTH-1:0] val,
    output logic             full
);

    logic [WIDTH-1:0] val_reg;
    logic [WIDTH-1:0] val_next;
    logic             full_reg;
    logic             full_next;
    logic             take;

    // new word belongs at or before this slot
    assign gt   = !full_reg || (val_reg > new_val);
    assign take = ins && gt;

    // left neighbour moving right hands its word on, else the new word lands here
    assign val_next  = left_gt ? left_val : new_val;
    assign full_next = left_gt ? left_full : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (clr)
        begin
            full_reg <= 1'b0;
        end
        else if (take)
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            val_reg <= val_next;
        end
    end

    assign val  = val_reg;
    assign full = full_reg;

endmodule

// ----- design/mmse_sort_chain.sv -----
// Row of sort cells with a fill count; one insertion a cycle.
module mmse_sort_chain #(
    parameter int DEPTH = mmse_pkg::MAX_CORNERS_DEF,
    parameter int WIDTH = mmse_pkg::Q_W,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ins,
    input  logic                        clr,
    input  logic [WIDTH-1:0]            new_val,
    output logic [DEPTH-1:0][WIDTH-1:0] vals,
    output logic [CW-1:0]               count
);

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             ins_ok;
    logic [DEPTH-1:0] gt;
    logic [DEPTH-1:0] full;

    // words past capacity are dropped
    assign ins_ok = ins && (count_reg < CW'(DEPTH));

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                mmse_sort_cell #(.WIDTH(WIDTH)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ins       (ins_ok),
                    .clr       (clr),
                    .new_val   (new_val),
                    .left_gt   (1'b0),
                    .left_val  (new_val),
                    .left_full (1'b1),
                    .gt        (gt[i]),
                    .val       (vals[i]),
                    .full      (full[i])
                );
            end
            else
            begin : g_body
                mmse_sort_cell #(.WIDTH(WIDTH)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ins       (ins_ok),
                    .clr       (clr),
                    .new_val   (new_val),
                    .left_gt   (gt[i-1]),
                    .left_val  (vals[i-1]),
                    .left_full (full[i-1]),
                    .gt        (gt[i]),
                    .val       (vals[i]),
                    .full      (full[i])
                );
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (clr)
        begin
            count_next = '0;
        end
        else if (ins_ok)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// ----- design/mmse_divider.sv -----
// Saturating Q8.16 divide, floor(a * 2^16 / b), restoring, one bit a cycle.
// Divisor must be nonzero. Saturated results are done in the cycle after start.
module mmse_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  mmse_pkg::div_req_t  req,
    output mmse_pkg::div_stat_t stat
);

    localparam int QW = mmse_pkg::Q_W;
    localparam int IW = mmse_pkg::INT_W;
    localparam int CW = mmse_pkg::DIV_CNT_W;

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [QW-1:0] rem_reg;
    logic [QW-1:0] rem_next;
    logic [QW-1:0] den_reg;
    logic [QW-1:0] den_next;
    logic [QW-1:0] quo_reg;
    logic [QW-1:0] quo_next;

    logic          sat;
    logic [QW:0]   rem_sh;
    logic          ge;

    // quotient fits only when a >> 8 is below b
    assign sat    = {{IW{1'b0}}, req.dividend[QW-1:IW]} >= req.divisor;
    assign rem_sh = {rem_reg, quo_reg[QW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            den_next = req.divisor;
            if (sat)
            begin
                quo_next  = mmse_pkg::Q_MAX;
                done_next = 1'b1;
            end
            else
            begin
                // low dividend bits ride in the quotient register
                rem_next  = {{IW{1'b0}}, req.dividend[QW-1:IW]};
                quo_next  = {req.dividend[IW-1:0], {mmse_pkg::FRAC_W{1'b0}}};
                cnt_next  = CW'(mmse_pkg::DIV_STEPS);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? QW'(rem_sh - {1'b0, den_reg}) : rem_sh[QW-1:0];
            quo_next = {quo_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

// ----- design/masked_median_scale_estimator.sv -----
// Masked median scale estimator. Depth samples arrive one word per cycle while
// in_stall is low and are insertion-sorted into a row of (2*WINDOW_RADIUS+1)^2
// cells as they come; masked samples and samples beyond the row's capacity are
// dropped. A word with last_in_window or last_corner closes the window: the
// upper median is read from the row and, when the row is not empty, the
// median is nonzero and fewer than MAX_CORNERS ratios are held,
// corner_depth/median is formed by a shared bit-serial divider (a load then
// one quotient bit a cycle, the load alone when the ratio saturates) and
// sorted into a second row of MAX_CORNERS cells. A word with last_corner then
// takes the upper median ratio as the factor when at least min_corners ratios
// are held, divides the larger of the distances from the smallest and largest
// ratio to it by the factor for the spread (a zero factor saturates it), and
// emits one result word once the output register is free. The closing steps
// also wait for any held result to leave; in_stall is high throughout them.
// A finished result may wait in the output register while new samples are
// taken. min_corners (reset 3, 0 read as 1) is written via the cfg channel,
// which is always ready; write it only while idle.
module masked_median_scale_estimator #(
    parameter int WINDOW_RADIUS = mmse_pkg::WINDOW_RADIUS_DEF,
    parameter int MAX_CORNERS   = mmse_pkg::MAX_CORNERS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mmse_pkg::CFG_W-1:0]  cfg_data,
    // sample words
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mmse_pkg::Q_W-1:0]    depth_sample,
    input  logic                        sample_valid,
    input  logic [mmse_pkg::Q_W-1:0]    corner_depth,
    input  logic                        last_in_window,
    input  logic                        last_corner,
    // result words
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        scale_found,
    output logic [mmse_pkg::Q_W-1:0]    factor,
    output logic [mmse_pkg::Q_W-1:0]    spread,
    output logic [mmse_pkg::USED_W-1:0] corners_used
);

    localparam int QW      = mmse_pkg::Q_W;
    localparam int WIN_CAP = (2 * WINDOW_RADIUS + 1) * (2 * WINDOW_RADIUS + 1);
    localparam int WC_W    = $clog2(WIN_CAP + 1);
    localparam int WI_W    = $clog2(WIN_CAP);
    localparam int RC_W    = $clog2(MAX_CORNERS + 1);
    localparam int RI_W    = $clog2(MAX_CORNERS);

    typedef enum logic [5:0] {
        S_IDLE       = 6'b000001,
        S_MEDIAN     = 6'b000010,
        S_DIV_RATIO  = 6'b000100,
        S_FINAL      = 6'b001000,
        S_DIV_SPREAD = 6'b010000,
        S_RESULT     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [mmse_pkg::CFG_W-1:0] min_corners_reg;

    // word held for the closing steps
    logic [QW-1:0] corner_reg;
    logic [QW-1:0] corner_next;
    logic          end_all_reg;
    logic          end_all_next;

    // result under construction
    logic          found_hold_reg;
    logic          found_hold_next;
    logic [QW-1:0] factor_hold_reg;
    logic [QW-1:0] factor_hold_next;
    logic [QW-1:0] spread_hold_reg;
    logic [QW-1:0] spread_hold_next;

    // output register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        scale_found_reg;
    logic [QW-1:0]               factor_reg;
    logic [QW-1:0]               spread_reg;
    logic [mmse_pkg::USED_W-1:0] corners_used_reg;

    logic in_accept;
    logic result_load;

    // window row
    logic                        win_ins;
    logic                        win_clr;
    logic [WIN_CAP-1:0][QW-1:0]  win_vals;
    logic [WC_W-1:0]             win_cnt;
    logic [QW-1:0]               win_med;

    // ratio row
    logic                          rat_ins;
    logic                          rat_clr;
    logic [MAX_CORNERS-1:0][QW-1:0] rat_vals;
    logic [RC_W-1:0]               rat_cnt;
    logic [QW-1:0]                 rat_mid;
    logic [QW-1:0]                 rat_min;
    logic [QW-1:0]                 rat_max;
    logic [QW-1:0]                 dev_lo;
    logic [QW-1:0]                 dev_hi;
    logic [QW-1:0]                 dev_max;

    logic [mmse_pkg::CFG_W-1:0]  need;
    logic                        found_w;
    logic                        ratio_go;
    logic [mmse_pkg::USED_W-1:0] used_w;

    mmse_pkg::div_req_t  div_req;
    mmse_pkg::div_stat_t div_stat;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_corners_reg <= mmse_pkg::MIN_CORNERS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            min_corners_reg <= cfg_data;
        end
    end

    // sorted rows
    assign win_ins = in_accept && sample_valid;
    assign win_clr = (state_reg == S_MEDIAN);

    mmse_sort_chain #(.DEPTH(WIN_CAP), .WIDTH(QW)) u_win (
        .clk     (clk),
        .rst_n   (rst_n),
        .ins     (win_ins),
        .clr     (win_clr),
        .new_val (depth_sample),
        .vals    (win_vals),
        .count   (win_cnt)
    );

    assign rat_ins = (state_reg == S_DIV_RATIO) && div_stat.done;
    assign rat_clr = result_load;

    mmse_sort_chain #(.DEPTH(MAX_CORNERS), .WIDTH(QW)) u_rat (
        .clk     (clk),
        .rst_n   (rst_n),
        .ins     (rat_ins),
        .clr     (rat_clr),
        .new_val (div_stat.quotient),
        .vals    (rat_vals),
        .count   (rat_cnt)
    );

    mmse_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // upper medians, element count/2 of each row
    assign win_med = win_vals[WI_W'(win_cnt >> 1)];
    assign rat_mid = rat_vals[RI_W'(rat_cnt >> 1)];
    assign rat_min = rat_vals[0];
    assign rat_max = rat_vals[RI_W'(rat_cnt - 1'b1)];

    // largest |ratio - factor| comes from one end of the sorted row
    assign dev_lo  = rat_mid - rat_min;
    assign dev_hi  = rat_max - rat_mid;
    assign dev_max = (dev_hi > dev_lo) ? dev_hi : dev_lo;

    assign need     = (min_corners_reg == '0) ? mmse_pkg::CFG_W'(1) : min_corners_reg;
    assign found_w  = 32'(rat_cnt) >= 32'(need);
    assign ratio_go = (win_cnt != '0) && (win_med != '0)
                      && (rat_cnt < RC_W'(MAX_CORNERS));
    assign used_w   = (32'(rat_cnt) > 32'(mmse_pkg::USED_MAX))
                      ? mmse_pkg::USED_MAX : mmse_pkg::USED_W'(rat_cnt);

    assign result_load = (state_reg == S_RESULT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next       = state_reg;
        corner_next      = corner_reg;
        end_all_next     = end_all_reg;
        found_hold_next  = found_hold_reg;
        factor_hold_next = factor_hold_reg;
        spread_hold_next = spread_hold_reg;
        div_req.start    = 1'b0;
        div_req.dividend = corner_reg;
        div_req.divisor  = win_med;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (last_in_window || last_corner))
                begin
                    corner_next  = corner_depth;
                    end_all_next = last_corner;
                    state_next   = S_MEDIAN;
                end
            end
            S_MEDIAN:
            begin
                if (ratio_go)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV_RATIO;
                end
                else
                begin
                    state_next = end_all_reg ? S_FINAL : S_IDLE;
                end
            end
            S_DIV_RATIO:
            begin
                if (div_stat.done)
                begin
                    state_next = end_all_reg ? S_FINAL : S_IDLE;
                end
            end
            S_FINAL:
            begin
                found_hold_next  = found_w;
                factor_hold_next = found_w ? rat_mid : '0;
                // zero factor saturates the spread
                spread_hold_next = found_w ? mmse_pkg::Q_MAX : '0;
                div_req.dividend = dev_max;
                div_req.divisor  = rat_mid;
                if (found_w && (rat_mid != '0))
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV_SPREAD;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_DIV_SPREAD:
            begin
                div_req.dividend = dev_max;
                div_req.divisor  = rat_mid;
                if (div_stat.done)
                begin
                    spread_hold_next = div_stat.quotient;
                    state_next       = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (result_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        corner_reg      <= corner_next;
        end_all_reg     <= end_all_next;
        found_hold_reg  <= found_hold_next;
        factor_hold_reg <= factor_hold_next;
        spread_hold_reg <= spread_hold_next;
        if (result_load)
        begin
            scale_found_reg  <= found_hold_reg;
            factor_reg       <= factor_hold_reg;
            spread_reg       <= spread_hold_reg;
            corners_used_reg <= used_w;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scale_found  = scale_found_reg;
    assign factor       = factor_reg;
    assign spread       = spread_reg;
    assign corners_used = corners_used_reg;

endmodule

// ----- bench/tb_masked_median_scale_estimator.sv -----
module tb_masked_median_scale_estimator;

    import mmse_pkg::*;

    // geometry of the block as instantiated (package defaults)
    localparam int WIN_SIDE  = 2 * WINDOW_RADIUS_DEF + 1;
    localparam int WIN_CAP   = WIN_SIDE * WIN_SIDE;
    localparam int RATIO_CAP = MAX_CORNERS_DEF;

    // room for the worst window close plus final corner; allow margin
    localparam int DRAIN_CYCLES   = 64;
    // longest quiet spell: final corner, long stall on each side, drain pause
    localparam int WATCHDOG_LIMIT = 2000;

    // one sample word as it crosses the input channel
    typedef struct packed {
        logic [Q_W-1:0] depth;
        logic           valid;
        logic [Q_W-1:0] corner;
        logic           last_win;
        logic           last_all;
    } sample_word_t;

    // one scale report word
    typedef struct packed {
        logic              found;
        logic [Q_W-1:0]    factor;
        logic [Q_W-1:0]    spread;
        logic [USED_W-1:0] used;
    } scale_report_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data  = '0;

    logic              in_valid       = 1'b0;
    logic              in_stall;
    logic [Q_W-1:0]    depth_sample   = '0;
    logic              sample_valid   = 1'b0;
    logic [Q_W-1:0]    corner_depth   = '0;
    logic              last_in_window = 1'b0;
    logic              last_corner    = 1'b0;

    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              scale_found;
    logic [Q_W-1:0]    factor;
    logic [Q_W-1:0]    spread;
    logic [USED_W-1:0] corners_used;

    always #6 clk = ~clk;

    masked_median_scale_estimator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .depth_sample   (depth_sample),
        .sample_valid   (sample_valid),
        .corner_depth   (corner_depth),
        .last_in_window (last_in_window),
        .last_corner    (last_corner),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .scale_found    (scale_found),
        .factor         (factor),
        .spread         (spread),
        .corners_used   (corners_used)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the window row, the ratio row and
    // the threshold register. Both rows are kept sorted on insertion, so
    // the upper median is simply entry count/2.
    // ------------------------------------------------------------------
    logic [Q_W-1:0]   win_row [WIN_CAP];
    int               win_cnt = 0;
    logic [Q_W-1:0]   ratio_row [RATIO_CAP];
    int               ratio_cnt = 0;
    logic [CFG_W-1:0] min_corners_q = MIN_CORNERS_RST;

    // reports still owed by the block, oldest first
    scale_report_t    pending_reports [$];

    int err_count  = 0;
    int n_words    = 0;
    int n_reports  = 0;
    int n_found    = 0;
    int n_cfg      = 0;
    int quiet_cnt  = 0;

    // idling controls, flipped per frame by the stimulus
    bit tx_gap_en  = 1'b0;
    bit rx_stall_en = 1'b0;
    int stall_left = 0;

    // floor(num * 2^16 / den), clamped to the Q8.16 ceiling
    function automatic logic [Q_W-1:0] q16_div_sat(input logic [Q_W-1:0] num,
                                                   input logic [Q_W-1:0] den);
        logic [2*Q_W-1:0] quo;
        quo = ({{Q_W{1'b0}}, num} << FRAC_W) / {{Q_W{1'b0}}, den};
        if (quo > {{Q_W{1'b0}}, Q_MAX})
            return Q_MAX;
        return quo[Q_W-1:0];
    endfunction

    function automatic void win_insert(input logic [Q_W-1:0] v);
        int j;
        j = win_cnt;
        while (j > 0 && win_row[j-1] > v)
        begin
            win_row[j] = win_row[j-1];
            j--;
        end
        win_row[j] = v;
        win_cnt++;
    endfunction

    function automatic void ratio_insert(input logic [Q_W-1:0] v);
        int j;
        j = ratio_cnt;
        while (j > 0 && ratio_row[j-1] > v)
        begin
            ratio_row[j] = ratio_row[j-1];
            j--;
        end
        ratio_row[j] = v;
        ratio_cnt++;
    endfunction

    // Advance the predictor by one accepted word; returns 1 with the
    // expected report when the word closes the last corner.
    function automatic bit predict_scale(input sample_word_t w, output scale_report_t r);
        logic [Q_W-1:0] med;
        logic [Q_W-1:0] fac;
        logic [Q_W-1:0] dist_abs;
        logic [Q_W-1:0] dev;
        logic [Q_W-1:0] worst;
        int             need;
        int             i;
        r = '0;
        // masked samples and samples past the row's capacity are dropped
        if (w.valid && win_cnt < WIN_CAP)
            win_insert(w.depth);
        // last_corner closes the open window too
        if (w.last_win || w.last_all)
        begin
            if (win_cnt > 0)
            begin
                med = win_row[win_cnt / 2];
                // zero median gives no ratio; excess corners ignored
                if (med != '0 && ratio_cnt < RATIO_CAP)
                    ratio_insert(q16_div_sat(w.corner, med));
            end
            win_cnt = 0;
        end
        if (!w.last_all)
            return 1'b0;
        // a threshold of zero still needs one ratio
        need = (min_corners_q == '0) ? 1 : int'(min_corners_q);
        r.found = (ratio_cnt >= need);
        if (r.found)
        begin
            fac = ratio_row[ratio_cnt / 2];
            r.factor = fac;
            if (fac == '0)
                r.spread = Q_MAX;
            else
            begin
                worst = '0;
                for (i = 0; i < ratio_cnt; i++)
                begin
                    dist_abs = (ratio_row[i] > fac) ? ratio_row[i] - fac
                                                    : fac - ratio_row[i];
                    dev  = q16_div_sat(dist_abs, fac);
                    if (dev > worst)
                        worst = dev;
                end
                r.spread = worst;
            end
        end
        r.used = (ratio_cnt > int'(USED_MAX)) ? USED_MAX : USED_W'(ratio_cnt);
        win_cnt   = 0;
        ratio_cnt = 0;
        return 1'b1;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic sample_word_t mk_word(input logic [Q_W-1:0] depth, input logic valid,
                                             input logic [Q_W-1:0] corner, input logic lw,
                                             input logic lc);
        sample_word_t w;
        w.depth    = depth;
        w.valid    = valid;
        w.corner   = corner;
        w.last_win = lw;
        w.last_all = lc;
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [Q_W-1:0] want,
                                        input logic [Q_W-1:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional gap, then hold the word until the block takes it.
    // Handshakes are sampled at the edge, before any register update.
    // ------------------------------------------------------------------
    task automatic send_word(input sample_word_t w);
        int            gap;
        scale_report_t rep;
        gap = (tx_gap_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        depth_sample   <= w.depth;
        sample_valid   <= w.valid;
        corner_depth   <= w.corner;
        last_in_window <= w.last_win;
        last_corner    <= w.last_all;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        n_words++;
        if (predict_scale(w, rep))
            pending_reports.insert(pending_reports.size(), rep);
    endtask

    // Threshold writes only while idle: every report in, then a pause long
    // enough for a window close that owes no report to finish.
    task automatic write_min_corners(input logic [CFG_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid     <= 1'b0;
        min_corners_q = v;
        n_cfg++;
    endtask

    // ------------------------------------------------------------------
    // One frame of corners with random content. Window styles:
    //   0 - depths clustered round the corner depth, ratios near unity
    //   1 - full-range depths and corners
    //   2 - tiny depths, zero medians and saturating ratios
    //   3 - mostly masked samples
    // About one frame in ten has broken boundaries (stray last flags,
    // possibly no final corner at all).
    // ------------------------------------------------------------------
    task automatic send_frame();
        int             n_win;
        int             len;
        int             wi;
        int             k;
        int             style;
        bit             broken;
        bit             long_win;
        logic [Q_W-1:0] base;
        sample_word_t   w;
        broken = ($urandom_range(0, 9) == 0);
        n_win  = $urandom_range(1, 6);
        // a fifth of frames run with no idling at all
        if ($urandom_range(0, 4) == 0)
        begin
            tx_gap_en   = 1'b0;
            rx_stall_en = 1'b0;
        end
        else
        begin
            tx_gap_en   = $urandom_range(0, 3) != 0;
            rx_stall_en = $urandom_range(0, 3) != 0;
        end
        for (wi = 0; wi < n_win; wi++)
        begin
            // occasional long window, which can overrun the row
            long_win = ($urandom_range(0, 11) == 0);
            len   = long_win ? $urandom_range(20, 32) : $urandom_range(1, 6);
            style = $urandom_range(0, 3);
            base  = Q_W'($urandom_range('h8000, 'h40000));
            for (k = 0; k < len; k++)
            begin
                case (style)
                    0: w.depth = Q_W'(base + $urandom_range(0, 'h1000) - 'h800);
                    1: w.depth = Q_W'($urandom_range(0, Q_MAX));
                    2: w.depth = Q_W'($urandom_range(0, 3));
                    default: w.depth = Q_W'($urandom_range(0, Q_MAX));
                endcase
                if (long_win)
                    w.valid = $urandom_range(0, 9) != 0;
                else if (style == 3)
                    w.valid = $urandom_range(0, 3) == 0;
                else
                    w.valid = $urandom_range(0, 4) != 0;
                // corner depth only matters on the closing word
                if (style == 0 && k == len - 1)
                    w.corner = Q_W'(base + $urandom_range(0, 'h4000) - 'h2000);
                else
                    w.corner = Q_W'($urandom_range(0, Q_MAX));
                w.last_win = (k == len - 1);
                w.last_all = (k == len - 1) && (wi == n_win - 1);
                if (w.last_all)
                    w.last_win = 1'($urandom_range(0, 1));
                if (broken)
                begin
                    w.last_win = $urandom_range(0, 5) == 0;
                    w.last_all = $urandom_range(0, 15) == 0;
                end
                send_word(w);
            end
        end
    endtask

    task automatic run_frames(input int quota);
        int stop_at;
        stop_at = n_words + quota;
        while (n_words < stop_at)
            send_frame();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked frames at the reset threshold of three.
    task automatic test_directed_cases();
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        // extremes: unity ratio, saturating ratio, masked word in a window,
        // final corner closed by last_corner alone
        send_word(mk_word('hFFFFFF, 1'b1, 'hFFFFFF, 1'b1, 1'b0));
        send_word(mk_word('h000001, 1'b1, 'hFFFFFF, 1'b1, 1'b0));
        send_word(mk_word('h000100, 1'b1, 'h000000, 1'b0, 1'b0));
        send_word(mk_word('hABCDEF, 1'b0, 'h000080, 1'b1, 1'b0));
        send_word(mk_word('h010000, 1'b1, 'h123456, 1'b0, 1'b0));
        send_word(mk_word('h030000, 1'b1, 'h018000, 1'b0, 1'b1));
        // zero median and an all-masked window: no ratio, no factor
        send_word(mk_word('h000000, 1'b1, 'h000005, 1'b1, 1'b0));
        send_word(mk_word('h000007, 1'b0, 'hFFFFFF, 1'b1, 1'b0));
        send_word(mk_word('hFFFFFF, 1'b0, 'hFFFFFF, 1'b0, 1'b1));
        // zero corner depths give a zero factor, spread pinned high
        send_word(mk_word('h000001, 1'b1, 'h000000, 1'b1, 1'b0));
        send_word(mk_word('hFFFFFF, 1'b1, 'h000000, 1'b1, 1'b0));
        send_word(mk_word('h000005, 1'b1, 'h000000, 1'b0, 1'b1));
        // two ratios only, both last flags on the final word
        send_word(mk_word('h020000, 1'b1, 'h020000, 1'b1, 1'b0));
        send_word(mk_word('h010000, 1'b1, 'h030000, 1'b1, 1'b1));
        // five corners: the fifth ratio falls off the end
        send_word(mk_word('h010000, 1'b1, 'h010000, 1'b1, 1'b0));
        send_word(mk_word('h010000, 1'b1, 'h018000, 1'b1, 1'b0));
        send_word(mk_word('h010000, 1'b1, 'h008000, 1'b1, 1'b0));
        send_word(mk_word('h010000, 1'b1, 'h020000, 1'b1, 1'b0));
        send_word(mk_word('h010000, 1'b1, 'h040000, 1'b0, 1'b1));
    endtask

    // Threshold at its edges: zero (read as one), the top of the range, which no
    // frame can ever reach, the bottom, and the ratio row's capacity.
    task automatic test_threshold_extremes();
        write_min_corners(CFG_W'(0));
        run_frames(130);
        write_min_corners(CFG_W'(7));
        run_frames(100);
        write_min_corners(CFG_W'(1));
        run_frames(130);
        write_min_corners(CFG_W'(4));
        run_frames(150);
    endtask

    // Bulk random traffic at thresholds of 2, 3, 5 and 1.
    task automatic test_random_traffic();
        write_min_corners(CFG_W'(2));
        run_frames(200);
        write_min_corners(MIN_CORNERS_RST);
        run_frames(200);
        write_min_corners(CFG_W'(5));
        run_frames(100);
        write_min_corners(CFG_W'(1));
        run_frames(80);
    endtask

    // ------------------------------------------------------------------
    // Receiver stall: runs of stall and of ready, mostly short
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rx_stall_en)
            out_stall <= 1'b0;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if ($urandom_range(0, 2) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= pick_gap();
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end
    end

    // ------------------------------------------------------------------
    // Report checker: each accepted word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : report_check
        scale_report_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            n_reports++;
            if (scale_found === 1'b1)
                n_found++;
            if (pending_reports.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected report word, found %b factor %h spread %h used %0d",
                         $time, scale_found, factor, spread, corners_used);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("scale_found", Q_W'(want.found), Q_W'(scale_found));
                check_field("factor", want.factor, factor);
                check_field("spread", want.spread, spread);
                check_field("corners_used", Q_W'(want.used), Q_W'(corners_used));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too many cycles with no handshake on any channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
            || (cfg_valid && cfg_ready === 1'b1))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d reports outstanding",
                     $time, quiet_cnt, pending_reports.size());
            $display("masked_median_scale_estimator verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_threshold_extremes();
        test_random_traffic();

        // let the block run dry, then wait out any trailing work
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d sample words and %0d scale reports (%0d with a factor),",
                 n_words, n_reports, n_found);
        $display("across %0d threshold writes including zero and out-of-range values.", n_cfg);
        if (err_count == 0 && pending_reports.size() == 0)
            $display("masked_median_scale_estimator verification clean");
        else
            $display("masked_median_scale_estimator verification failed");
        $finish;
    end

endmodule
